### design/tx86_pkg.sv
// Shared types, codes and constants of the toy x86 operand and execute unit.
package tx86_pkg;

  localparam int unsigned MEM_WORDS  = 1024;
  localparam int unsigned INST_BYTES = 64;
  localparam int unsigned WORD_BYTES = 8;
  localparam int unsigned REGS       = 16;

  localparam int unsigned REG_AW = $clog2(REGS);
  localparam int unsigned MEM_AW = $clog2(MEM_WORDS);
  localparam int unsigned PA_W   = MEM_AW + $clog2(WORD_BYTES);

  localparam logic [REG_AW-1:0] STACK_REG = REG_AW'(4);

  localparam int unsigned IN_DATA_W  = 168;
  localparam int unsigned OUT_DATA_W = 328;

  typedef enum logic [1:0] {
    KIND_EXEC     = 2'd0,
    KIND_LOAD_MEM = 2'd1,
    KIND_LOAD_REG = 2'd2,
    KIND_SET_PC   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    OP_MOVRR = 3'd0,
    OP_CALL  = 3'd1,
    OP_ADDRR = 3'd2,
    OP_PUSH  = 3'd3,
    OP_POP   = 3'd4,
    OP_MOVRM = 3'd5,
    OP_MOVMR = 3'd6,
    OP_RET   = 3'd7
  } op_t;

  localparam logic [3:0] MODE_NONE           = 4'd0;
  localparam logic [3:0] MODE_IMM            = 4'd1;
  localparam logic [3:0] MODE_REG            = 4'd2;
  localparam logic [3:0] MODE_ABS            = 4'd3;
  localparam logic [3:0] MODE_BASE           = 4'd4;
  localparam logic [3:0] MODE_IMM_BASE       = 4'd5;
  localparam logic [3:0] MODE_BASE_IDX       = 4'd6;
  localparam logic [3:0] MODE_IMM_BASE_IDX   = 4'd7;
  localparam logic [3:0] MODE_SIDX           = 4'd8;
  localparam logic [3:0] MODE_IMM_SIDX       = 4'd9;
  localparam logic [3:0] MODE_IMM_BASE_SIDX  = 4'd10;

  typedef struct packed {
    kind_t             kind;
    op_t               opcode;
    logic [3:0]        src_mode;
    logic [63:0]       src_imm;
    logic [REG_AW-1:0] src_base;
    logic [REG_AW-1:0] src_index;
    logic [3:0]        src_scale;
    logic [3:0]        dst_mode;
    logic [63:0]       dst_imm;
    logic [REG_AW-1:0] dst_base;
    logic [REG_AW-1:0] dst_index;
    logic [3:0]        dst_scale;
  } inst_t;

  typedef struct packed {
    logic [63:0]       next_pc;
    logic [63:0]       stack_ptr;
    logic              reg_written;
    logic [REG_AW-1:0] reg_number;
    logic [63:0]       reg_value;
    logic              mem_written;
    logic [63:0]       mem_addr;
    logic [63:0]       mem_value;
  } res_t;

  typedef struct packed {
    logic [REG_AW-1:0] ra;
    logic [REG_AW-1:0] rb;
    logic              we;
    logic [REG_AW-1:0] wa;
    logic [63:0]       wd;
  } rf_req_t;

  typedef struct packed {
    logic [MEM_AW-1:0] addr;
    logic              we;
    logic [63:0]       wd;
  } dm_req_t;

endpackage

### design/tx86_regfile.sv
// Register file: 16 words, two registered read ports, one write port, cleared by valid bits.
module tx86_regfile
  import tx86_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  rf_req_t     req,
  output logic [63:0] rd_a,
  output logic [63:0] rd_b
);

  logic [63:0]     mem [REGS];
  logic [REGS-1:0] vld_r;
  logic            va_r;
  logic            vb_r;
  logic [63:0]     qa_r;
  logic [63:0]     qb_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.wa] <= req.wd;
    end
    qa_r <= mem[req.ra];
    qb_r <= mem[req.rb];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      va_r  <= 1'b0;
      vb_r  <= 1'b0;
    end else begin
      if (req.we) begin
        vld_r[req.wa] <= 1'b1;
      end
      va_r <= vld_r[req.ra];
      vb_r <= vld_r[req.rb];
    end
  end

  assign rd_a = va_r ? qa_r : '0;
  assign rd_b = vb_r ? qb_r : '0;

endmodule

### design/tx86_dmem.sv
// Single-port data store with a registered read.
module tx86_dmem
  import tx86_pkg::*;
(
  input  logic        clk,
  input  dm_req_t     req,
  output logic [63:0] rdata
);

  logic [63:0] mem [MEM_WORDS];
  logic [63:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wd;
    end
    rdata_r <= mem[req.addr];
  end

  assign rdata = rdata_r;

endmodule

### design/tx86_ctrl.sv
// Sequencer: register reads, address generation, operand fetch, execute and write back.
module tx86_ctrl
  import tx86_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_fire,
  input  inst_t       in_item,
  output logic        in_ready,
  output rf_req_t     rf_req,
  input  logic [63:0] rf_rd_a,
  input  logic [63:0] rf_rd_b,
  output dm_req_t     dm_req,
  input  logic [63:0] dm_rdata,
  output logic        res_valid,
  input  logic        res_ready,
  output res_t        res
);

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_RD1  = 9'b000000010,
    ST_RD2  = 9'b000000100,
    ST_ADDR = 9'b000001000,
    ST_MRD  = 9'b000010000,
    ST_MCAP = 9'b000100000,
    ST_EXE  = 9'b001000000,
    ST_WB2  = 9'b010000000,
    ST_DONE = 9'b100000000
  } state_t;

  state_t      st_r, st_nxt;
  inst_t       item_r;
  logic [63:0] pc_r, pc_nxt;
  res_t        res_r, res_nxt;
  logic        wb2_r, wb2_nxt;
  logic [63:0] sb_val_r, sx_val_r, sxs_r;
  logic [63:0] db_val_r, dx_val_r, dxs_r;
  logic [63:0] sp_r, sa_r, da_r, sv_mem_r;

  logic [63:0] src_val, dst_val, pc_inc, sp_dec, sp_inc;
  logic [63:0] ex_pc, ex_sp_val, ex_rv, ex_ma, ex_mv;
  logic        ex_sp_upd, ex_rw, ex_mw;
  logic [REG_AW-1:0] ex_rn;
  logic        wr_en;
  logic [3:0]  wr_mode;
  logic [REG_AW-1:0] wr_base;
  logic [63:0] wr_addr, wr_val;

  function automatic logic is_mem(input logic [3:0] mode);
    return (mode >= MODE_ABS) && (mode <= MODE_IMM_BASE_SIDX);
  endfunction

  function automatic logic [63:0] phys(input logic [63:0] va);
    return 64'(va[PA_W-1:0]);
  endfunction

  function automatic logic [MEM_AW-1:0] word_of(input logic [63:0] va);
    return va[PA_W-1:PA_W-MEM_AW];
  endfunction

  function automatic logic [63:0] eff_addr(input logic [3:0] mode, input logic [63:0] imm,
                                           input logic [63:0] r1, input logic [63:0] r2,
                                           input logic [63:0] r2s);
    logic [63:0] ea;
    unique case (mode)
      MODE_ABS:           ea = imm;
      MODE_BASE:          ea = r1;
      MODE_IMM_BASE:      ea = imm + r1;
      MODE_BASE_IDX:      ea = r1 + r2;
      MODE_IMM_BASE_IDX:  ea = imm + r1 + r2;
      MODE_SIDX:          ea = r2s;
      MODE_IMM_SIDX:      ea = imm + r2s;
      MODE_IMM_BASE_SIDX: ea = imm + r1 + r2s;
      default:            ea = '0;
    endcase
    return ea;
  endfunction

  function automatic logic [63:0] opnd_val(input logic [3:0] mode, input logic [63:0] imm,
                                           input logic [63:0] regv, input logic [63:0] memv);
    logic [63:0] v;
    priority if (mode == MODE_IMM) v = imm;
    else if (mode == MODE_REG)     v = regv;
    else if (is_mem(mode))         v = memv;
    else                           v = '0;
    return v;
  endfunction

  assign in_ready  = (st_r == ST_IDLE);
  assign res_valid = (st_r == ST_DONE);
  assign res       = res_r;

  assign pc_inc  = pc_r + 64'(INST_BYTES);
  assign sp_dec  = sp_r - 64'(WORD_BYTES);
  assign sp_inc  = sp_r + 64'(WORD_BYTES);
  assign src_val = opnd_val(item_r.src_mode, item_r.src_imm, sb_val_r, sv_mem_r);
  assign dst_val = opnd_val(item_r.dst_mode, item_r.dst_imm, db_val_r, dm_rdata);

  always_comb begin
    ex_pc     = pc_r;
    ex_sp_upd = 1'b0;
    ex_sp_val = sp_r;
    ex_mw     = 1'b0;
    ex_ma     = '0;
    ex_mv     = '0;
    ex_rw     = 1'b0;
    ex_rn     = '0;
    ex_rv     = '0;
    wr_en     = 1'b0;
    wr_mode   = item_r.dst_mode;
    wr_base   = item_r.dst_base;
    wr_addr   = da_r;
    wr_val    = src_val;
    unique case (item_r.kind)
      KIND_LOAD_MEM: begin
        ex_mw = 1'b1;
        ex_ma = phys(item_r.dst_imm);
        ex_mv = item_r.src_imm;
      end
      KIND_LOAD_REG: begin
        ex_rw = 1'b1;
        ex_rn = item_r.dst_base;
        ex_rv = item_r.src_imm;
      end
      KIND_SET_PC: begin
        ex_pc = item_r.src_imm;
      end
      KIND_EXEC: begin
        unique case (item_r.opcode)
          OP_MOVRR, OP_MOVRM, OP_MOVMR: begin
            ex_pc = pc_inc;
            wr_en = 1'b1;
          end
          OP_ADDRR: begin
            ex_pc  = pc_inc;
            wr_en  = 1'b1;
            wr_val = dst_val + src_val;
          end
          OP_CALL: begin
            ex_sp_upd = 1'b1;
            ex_sp_val = sp_dec;
            ex_mw     = 1'b1;
            ex_ma     = phys(sp_dec);
            ex_mv     = pc_inc;
            ex_pc     = src_val;
          end
          OP_PUSH: begin
            ex_sp_upd = 1'b1;
            ex_sp_val = sp_dec;
            ex_mw     = 1'b1;
            ex_ma     = phys(sp_dec);
            ex_mv     = src_val;
            ex_pc     = pc_inc;
          end
          OP_POP: begin
            ex_sp_upd = 1'b1;
            ex_sp_val = sp_inc;
            ex_pc     = pc_inc;
            wr_en     = 1'b1;
            wr_mode   = item_r.src_mode;
            wr_base   = item_r.src_base;
            wr_addr   = sa_r;
            wr_val    = sv_mem_r;
          end
          OP_RET: begin
            ex_sp_upd = 1'b1;
            ex_sp_val = sp_inc;
            ex_pc     = sv_mem_r;
          end
        endcase
      end
    endcase
    if (wr_en) begin
      if (wr_mode == MODE_REG) begin
        ex_rw = 1'b1;
        ex_rn = wr_base;
        ex_rv = wr_val;
      end else if (is_mem(wr_mode)) begin
        ex_mw = 1'b1;
        ex_ma = phys(wr_addr);
        ex_mv = wr_val;
      end
    end
  end

  always_comb begin
    res_nxt             = res_r;
    wb2_nxt             = wb2_r;
    pc_nxt              = pc_r;
    if (st_r == ST_EXE) begin
      pc_nxt              = ex_pc;
      wb2_nxt             = ex_sp_upd && ex_rw;
      res_nxt.next_pc     = ex_pc;
      res_nxt.reg_written = ex_rw;
      res_nxt.reg_number  = ex_rn;
      res_nxt.reg_value   = ex_rv;
      res_nxt.mem_written = ex_mw;
      res_nxt.mem_addr    = ex_ma;
      res_nxt.mem_value   = ex_mv;
      if (ex_rw && (ex_rn == STACK_REG)) begin
        res_nxt.stack_ptr = ex_rv;
      end else if (ex_sp_upd) begin
        res_nxt.stack_ptr = ex_sp_val;
      end else begin
        res_nxt.stack_ptr = sp_r;
      end
    end
  end

  always_comb begin
    rf_req.ra = in_item.src_base;
    rf_req.rb = in_item.src_index;
    rf_req.we = 1'b0;
    rf_req.wa = ex_sp_upd ? STACK_REG : ex_rn;
    rf_req.wd = ex_sp_upd ? ex_sp_val : ex_rv;
    dm_req.addr = word_of(phys(sa_r));
    dm_req.we   = 1'b0;
    dm_req.wd   = ex_mv;
    unique case (st_r)
      ST_RD1: begin
        rf_req.ra = item_r.dst_base;
        rf_req.rb = item_r.dst_index;
      end
      ST_RD2: begin
        rf_req.ra = STACK_REG;
      end
      ST_MRD: begin
        if ((item_r.kind == KIND_EXEC) &&
            ((item_r.opcode == OP_POP) || (item_r.opcode == OP_RET))) begin
          dm_req.addr = word_of(phys(sp_r));
        end
      end
      ST_MCAP: begin
        dm_req.addr = word_of(phys(da_r));
      end
      ST_EXE: begin
        rf_req.we   = ex_sp_upd || ex_rw;
        dm_req.we   = ex_mw;
        dm_req.addr = word_of(ex_ma);
      end
      ST_WB2: begin
        rf_req.we = wb2_r;
        rf_req.wa = res_r.reg_number;
        rf_req.wd = res_r.reg_value;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: if (in_fire) st_nxt = ST_RD1;
      ST_RD1:  st_nxt = ST_RD2;
      ST_RD2:  st_nxt = ST_ADDR;
      ST_ADDR: st_nxt = ST_MRD;
      ST_MRD:  st_nxt = ST_MCAP;
      ST_MCAP: st_nxt = ST_EXE;
      ST_EXE:  st_nxt = ST_WB2;
      ST_WB2:  st_nxt = ST_DONE;
      ST_DONE: if (res_ready) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_IDLE;
      pc_r  <= '0;
      wb2_r <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      pc_r  <= pc_nxt;
      wb2_r <= wb2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (in_fire) begin
      item_r <= in_item;
    end
    if (st_r == ST_RD1) begin
      sb_val_r <= rf_rd_a;
      sx_val_r <= rf_rd_b;
      sxs_r    <= rf_rd_b * {60'd0, item_r.src_scale};
    end
    if (st_r == ST_RD2) begin
      db_val_r <= rf_rd_a;
      dx_val_r <= rf_rd_b;
      dxs_r    <= rf_rd_b * {60'd0, item_r.dst_scale};
    end
    if (st_r == ST_ADDR) begin
      sp_r <= rf_rd_a;
      sa_r <= eff_addr(item_r.src_mode, item_r.src_imm, sb_val_r, sx_val_r, sxs_r);
      da_r <= eff_addr(item_r.dst_mode, item_r.dst_imm, db_val_r, dx_val_r, dxs_r);
    end
    if (st_r == ST_MCAP) begin
      sv_mem_r <= dm_rdata;
    end
  end

endmodule

### design/toy_x86_operand_and_execute_unit_core.sv
// Top level of the toy x86 operand and execute unit: stream ports and output register.
//
// Each input word is one predecoded instruction or one preload command, with
// its kind on in_tuser. Every accepted word yields exactly one result word on
// the out_ channel, in order, giving the new program counter, the stack
// register and any register or memory write the word caused.
// The sequencer walks the register file's two read ports three times, then
// the single port of the data store three times, and writes back in two
// steps. A new word is taken only once the result of the last one has
// moved into the output register.
// The result sits in an output register, so a new input word is accepted
// while the previous result still waits. If that result has not been taken
// when the next one is finished, the block holds the finished result and
// keeps in_tready low until out_tready frees the register.
// Reset clears the program counter and all registers to zero; the data store
// holds no defined contents until words are written into it.
module toy_x86_operand_and_execute_unit_core
  import tx86_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // opcode, src_mode, src_imm, src_base, src_index, src_scale,
  // dst_mode, dst_imm, dst_base, dst_index, dst_scale, zero fill
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // kind
  input  logic [1:0]            in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // next_pc, stack_ptr, reg_number, reg_value, mem_addr, mem_value, zero fill
  output logic [OUT_DATA_W-1:0] out_tdata,
  // reg_written, mem_written
  output logic [1:0]            out_tuser
);

  inst_t       in_item;
  logic        in_fire;
  logic        res_valid;
  logic        res_ready;
  res_t        res;
  res_t        out_res_r;
  logic        out_valid_r;
  rf_req_t     rf_req;
  dm_req_t     dm_req;
  logic [63:0] rf_rd_a;
  logic [63:0] rf_rd_b;
  logic [63:0] dm_rdata;

  assign in_item.kind      = kind_t'(in_tuser);
  assign in_item.opcode    = op_t'(in_tdata[2:0]);
  assign in_item.src_mode  = in_tdata[6:3];
  assign in_item.src_imm   = in_tdata[70:7];
  assign in_item.src_base  = in_tdata[74:71];
  assign in_item.src_index = in_tdata[78:75];
  assign in_item.src_scale = in_tdata[82:79];
  assign in_item.dst_mode  = in_tdata[86:83];
  assign in_item.dst_imm   = in_tdata[150:87];
  assign in_item.dst_base  = in_tdata[154:151];
  assign in_item.dst_index = in_tdata[158:155];
  assign in_item.dst_scale = in_tdata[162:159];

  assign in_fire   = in_tvalid && in_tready;
  assign res_ready = !out_valid_r || out_tready;

  tx86_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_item   (in_item),
    .in_ready  (in_tready),
    .rf_req    (rf_req),
    .rf_rd_a   (rf_rd_a),
    .rf_rd_b   (rf_rd_b),
    .dm_req    (dm_req),
    .dm_rdata  (dm_rdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  tx86_regfile u_regfile (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (rf_req),
    .rd_a  (rf_rd_a),
    .rd_b  (rf_rd_b)
  );

  tx86_dmem u_dmem (
    .clk   (clk),
    .req   (dm_req),
    .rdata (dm_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_res_r.mem_value, out_res_r.mem_addr, out_res_r.reg_value,
                       out_res_r.reg_number, out_res_r.stack_ptr, out_res_r.next_pc};
  assign out_tuser  = {out_res_r.mem_written, out_res_r.reg_written};

endmodule

### tb/toy_x86_operand_and_execute_unit_core_test.sv
// Self-checking testbench for the toy x86 operand and execute unit core.
module toy_x86_operand_and_execute_unit_core_test;
  import tx86_pkg::*;

  localparam int ITEMS       = 1650;
  localparam int STALL_LIMIT = 1000;
  localparam int HOLD_CYCLES = 150;
  localparam int DRAIN       = 40;

  class x86_scoreboard;
    bit [63:0] regs [REGS];
    bit [63:0] pc;
    bit [63:0] words [MEM_WORDS];
    bit        written [MEM_WORDS];
    res_t      expected_q [$];
    res_t      fx;
    int        errors;

    function bit [63:0] phys(bit [63:0] va);
      return va % (64'(MEM_WORDS) * 64'(WORD_BYTES));
    endfunction

    function int word_of(bit [63:0] va);
      return int'(phys(va) >> 3);
    endfunction

    function bit is_mem(logic [3:0] mode);
      return mode >= MODE_ABS && mode <= MODE_IMM_BASE_SIDX;
    endfunction

    function bit [63:0] operand_addr(logic [3:0] mode, bit [63:0] imm, logic [3:0] b,
                                     logic [3:0] x, logic [3:0] s);
      case (mode)
        MODE_ABS:           return imm;
        MODE_BASE:          return regs[b];
        MODE_IMM_BASE:      return imm + regs[b];
        MODE_BASE_IDX:      return regs[b] + regs[x];
        MODE_IMM_BASE_IDX:  return imm + regs[b] + regs[x];
        MODE_SIDX:          return regs[x] * 64'(s);
        MODE_IMM_SIDX:      return imm + regs[x] * 64'(s);
        MODE_IMM_BASE_SIDX: return imm + regs[b] + regs[x] * 64'(s);
        default:            return 64'd0;
      endcase
    endfunction

    function void write_word(bit [63:0] va, bit [63:0] v);
      words[word_of(va)] = v;
      written[word_of(va)] = 1'b1;
      fx.mem_written = 1'b1;
      fx.mem_addr = phys(va);
      fx.mem_value = v;
    endfunction

    function void write_reg(logic [3:0] r, bit [63:0] v);
      regs[r] = v;
      fx.reg_written = 1'b1;
      fx.reg_number = r;
      fx.reg_value = v;
    endfunction

    function bit [63:0] fetch(logic [3:0] mode, bit [63:0] imm, logic [3:0] b,
                              bit [63:0] addr);
      if (mode == MODE_IMM) return imm;
      if (mode == MODE_REG) return regs[b];
      if (is_mem(mode)) return words[word_of(addr)];
      return 64'd0;
    endfunction

    function void store(logic [3:0] mode, logic [3:0] b, bit [63:0] addr, bit [63:0] v);
      if (mode == MODE_REG) write_reg(b, v);
      else if (is_mem(mode)) write_word(addr, v);
    endfunction

    // Index of a data word the word would read before anything was stored there.
    function int first_unread(inst_t w);
      bit [63:0] sa;
      bit [63:0] da;
      int        idx [$];
      if (w.kind != KIND_EXEC) return -1;
      sa = operand_addr(w.src_mode, w.src_imm, w.src_base, w.src_index, w.src_scale);
      da = operand_addr(w.dst_mode, w.dst_imm, w.dst_base, w.dst_index, w.dst_scale);
      if (w.opcode == OP_POP || w.opcode == OP_RET) begin
        idx.push_back(word_of(regs[STACK_REG]));
      end else begin
        if (is_mem(w.src_mode)) idx.push_back(word_of(sa));
        if (w.opcode == OP_ADDRR && is_mem(w.dst_mode)) idx.push_back(word_of(da));
      end
      foreach (idx[i]) if (!written[idx[i]]) return idx[i];
      return -1;
    endfunction

    function void note_word(inst_t w);
      bit [63:0] sa;
      bit [63:0] da;
      bit [63:0] sv;
      bit [63:0] dv;
      bit [63:0] sp;
      fx = '0;
      case (w.kind)
        KIND_LOAD_MEM: write_word(w.dst_imm, w.src_imm);
        KIND_LOAD_REG: write_reg(w.dst_base, w.src_imm);
        KIND_SET_PC:   pc = w.src_imm;
        default: begin
          sa = operand_addr(w.src_mode, w.src_imm, w.src_base, w.src_index, w.src_scale);
          da = operand_addr(w.dst_mode, w.dst_imm, w.dst_base, w.dst_index, w.dst_scale);
          sp = regs[STACK_REG];
          case (w.opcode)
            OP_MOVRR, OP_MOVRM, OP_MOVMR: begin
              sv = fetch(w.src_mode, w.src_imm, w.src_base, sa);
              store(w.dst_mode, w.dst_base, da, sv);
              pc += 64'(INST_BYTES);
            end
            OP_ADDRR: begin
              sv = fetch(w.src_mode, w.src_imm, w.src_base, sa);
              dv = fetch(w.dst_mode, w.dst_imm, w.dst_base, da);
              store(w.dst_mode, w.dst_base, da, dv + sv);
              pc += 64'(INST_BYTES);
            end
            OP_CALL: begin
              sv = fetch(w.src_mode, w.src_imm, w.src_base, sa);
              sp -= 64'(WORD_BYTES);
              regs[STACK_REG] = sp;
              write_word(sp, pc + 64'(INST_BYTES));
              pc = sv;
            end
            OP_PUSH: begin
              sv = fetch(w.src_mode, w.src_imm, w.src_base, sa);
              sp -= 64'(WORD_BYTES);
              regs[STACK_REG] = sp;
              write_word(sp, sv);
              pc += 64'(INST_BYTES);
            end
            OP_POP: begin
              sv = words[word_of(sp)];
              regs[STACK_REG] = sp + 64'(WORD_BYTES);
              pc += 64'(INST_BYTES);
              store(w.src_mode, w.src_base, sa, sv);
            end
            default: begin
              pc = words[word_of(sp)];
              regs[STACK_REG] = sp + 64'(WORD_BYTES);
            end
          endcase
        end
      endcase
      fx.next_pc = pc;
      fx.stack_ptr = regs[STACK_REG];
      expected_q.push_back(fx);
    endfunction

    function void compare(string field, bit [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $error("%s expected %h actual %h", field, want, got);
        errors++;
      end
    endfunction

    function void check_word(res_t got);
      res_t want;
      if (expected_q.size() == 0) begin
        $error("result word arrived with no word pending");
        errors++;
        return;
      end
      want = expected_q.pop_front();
      compare("next_pc", want.next_pc, got.next_pc);
      compare("stack_ptr", want.stack_ptr, got.stack_ptr);
      compare("reg_written", 64'(want.reg_written), 64'(got.reg_written));
      compare("reg_number", 64'(want.reg_number), 64'(got.reg_number));
      compare("reg_value", want.reg_value, got.reg_value);
      compare("mem_written", 64'(want.mem_written), 64'(got.mem_written));
      compare("mem_addr", want.mem_addr, got.mem_addr);
      compare("mem_value", want.mem_value, got.mem_value);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [1:0]            in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [1:0]            out_tuser;

  x86_scoreboard board = new;
  int            sent;
  int            quiet_cycles;
  bit            calm_in;
  bit            calm_out;

  toy_x86_operand_and_execute_unit_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic bit [63:0] random_value();
    case ($urandom_range(0, 3))
      0:       return {$urandom, $urandom};
      1:       return 64'($urandom_range(0, 255));
      2:       return ~64'($urandom_range(0, 255));
      default: return 64'($urandom_range(0, 1023)) << 3;
    endcase
  endfunction

  function automatic logic [3:0] random_mode();
    if ($urandom_range(0, 9) < 8) return 4'($urandom_range(0, 10));
    return 4'($urandom_range(0, 15));
  endfunction

  function automatic logic [3:0] random_scale();
    if ($urandom_range(0, 3) != 0) return 4'(1 << $urandom_range(0, 3));
    return 4'($urandom_range(0, 15));
  endfunction

  function automatic inst_t random_word();
    inst_t w;
    int    k;
    k = $urandom_range(0, 99);
    if (k < 8) w.kind = KIND_LOAD_MEM;
    else if (k < 18) w.kind = KIND_LOAD_REG;
    else if (k < 22) w.kind = KIND_SET_PC;
    else w.kind = KIND_EXEC;
    w.opcode = op_t'($urandom_range(0, 7));
    w.src_mode = random_mode();
    w.src_imm = random_value();
    w.src_base = $urandom_range(0, 3) == 0 ? STACK_REG : 4'($urandom_range(0, 15));
    w.src_index = 4'($urandom_range(0, 15));
    w.src_scale = random_scale();
    w.dst_mode = random_mode();
    w.dst_imm = random_value();
    w.dst_base = $urandom_range(0, 3) == 0 ? STACK_REG : 4'($urandom_range(0, 15));
    w.dst_index = 4'($urandom_range(0, 15));
    w.dst_scale = random_scale();
    return w;
  endfunction

  function automatic inst_t compose(kind_t k, op_t o, logic [3:0] s_mode, logic [63:0] s_imm,
                                    logic [3:0] s_base, logic [3:0] d_mode,
                                    logic [63:0] d_imm, logic [3:0] d_base);
    inst_t w;
    w = '0;
    w.kind = k;
    w.opcode = o;
    w.src_mode = s_mode;
    w.src_imm = s_imm;
    w.src_base = s_base;
    w.dst_mode = d_mode;
    w.dst_imm = d_imm;
    w.dst_base = d_base;
    return w;
  endfunction

  task automatic offer_word(inst_t w);
    int gap;
    gap = calm_in ? 0 : $urandom_range(0, 12);
    if ($urandom_range(0, 39) == 0) calm_in = !calm_in;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata <= {5'd0, w.dst_scale, w.dst_index, w.dst_base, w.dst_imm, w.dst_mode,
                 w.src_scale, w.src_index, w.src_base, w.src_imm, w.src_mode, w.opcode};
    in_tuser <= w.kind;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_word(w);
    sent++;
  endtask

  // Any data word the instruction reads that holds nothing yet is stored first.
  task automatic send_word(inst_t w);
    inst_t fill;
    int    miss;
    miss = board.first_unread(w);
    while (miss >= 0) begin
      fill = compose(KIND_LOAD_MEM, OP_MOVRR, MODE_NONE, {$urandom, $urandom}, 4'd0,
                     MODE_NONE, {$urandom, $urandom}, 4'd0);
      fill.dst_imm[PA_W-1:3] = MEM_AW'(miss);
      offer_word(fill);
      miss = board.first_unread(w);
    end
    offer_word(w);
  endtask

  task automatic stack_run();
    inst_t w;
    int    n;
    n = $urandom_range(1, 4);
    if ($urandom_range(0, 2) == 0) begin
      send_word(compose(KIND_LOAD_REG, OP_MOVRR, MODE_NONE,
                        64'($urandom_range(16, 1023)) << 3, 4'd0, MODE_NONE, 64'd0,
                        STACK_REG));
    end
    repeat (n) begin
      w = random_word();
      w.kind = KIND_EXEC;
      w.opcode = OP_PUSH;
      send_word(w);
    end
    if ($urandom_range(0, 1) == 0) begin
      w = random_word();
      w.kind = KIND_EXEC;
      w.opcode = OP_ADDRR;
      send_word(w);
    end
    repeat (n) begin
      w = random_word();
      w.kind = KIND_EXEC;
      w.opcode = OP_POP;
      if ($urandom_range(0, 1) == 0) w.src_mode = MODE_REG;
      send_word(w);
    end
  endtask

  task automatic call_run();
    inst_t w;
    int    n;
    n = $urandom_range(0, 3);
    w = random_word();
    w.kind = KIND_EXEC;
    w.opcode = OP_CALL;
    send_word(w);
    repeat (n) begin
      w = random_word();
      w.kind = KIND_EXEC;
      w.opcode = $urandom_range(0, 1) == 0 ? OP_ADDRR : OP_MOVRR;
      send_word(w);
    end
    w = random_word();
    w.kind = KIND_EXEC;
    w.opcode = OP_RET;
    send_word(w);
  endtask

  always @(posedge clk) begin : watch_results
    res_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.next_pc = out_tdata[63:0];
      got.stack_ptr = out_tdata[127:64];
      got.reg_number = out_tdata[131:128];
      got.reg_value = out_tdata[195:132];
      got.mem_addr = out_tdata[259:196];
      got.mem_value = out_tdata[323:260];
      got.reg_written = out_tuser[0];
      got.mem_written = out_tuser[1];
      board.check_word(got);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : drain_results
    int hold;
    int taken;
    taken = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (taken == 300 || taken == 1200) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      hold = calm_out ? 0 : $urandom_range(0, 12);
      if ($urandom_range(0, 39) == 0) calm_out = !calm_out;
      if (hold > 0) begin
        out_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      taken++;
    end
  end

  initial begin : stimulus
    inst_t w;
    int    m;
    int    pick;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    send_word(compose(KIND_LOAD_REG, OP_MOVRR, MODE_NONE, '1, 4'd0, MODE_NONE, 64'd0, 4'd15));
    send_word(compose(KIND_LOAD_REG, OP_MOVRR, MODE_NONE, 64'd24, 4'd0, MODE_NONE, 64'd0,
                      4'd2));
    send_word(compose(KIND_LOAD_REG, OP_MOVRR, MODE_NONE, 64'h800, 4'd0, MODE_NONE, 64'd0,
                      STACK_REG));
    send_word(compose(KIND_LOAD_MEM, OP_MOVRR, MODE_NONE, '1, 4'd0, MODE_NONE,
                      64'hFFFF_FFFF_FFFF_FFF8, 4'd0));
    send_word(compose(KIND_SET_PC, OP_MOVRR, MODE_NONE, 64'hFFFF_FFFF_FFFF_FFC0, 4'd0,
                      MODE_NONE, 64'd0, 4'd0));
    send_word(compose(KIND_EXEC, OP_MOVRR, MODE_IMM, '1, 4'd0, MODE_REG, 64'd0, 4'd0));
    send_word(compose(KIND_EXEC, OP_ADDRR, MODE_REG, 64'd0, 4'd15, MODE_REG, 64'd0, 4'd0));
    for (m = 3; m <= 10; m++) begin
      w = compose(KIND_EXEC, OP_MOVRR, 4'(m), 64'hFFFF_FFFF_FFFF_FFFB, 4'd15,
                  (m == 10) ? MODE_ABS : 4'(m + 1), 64'h13, 4'd2);
      w.src_index = 4'd2;
      w.src_scale = 4'(m + 5);
      w.dst_index = 4'd15;
      w.dst_scale = 4'(m - 3);
      send_word(w);
    end
    send_word(compose(KIND_EXEC, OP_PUSH, MODE_REG, 64'd0, 4'd15, MODE_NONE, 64'd0, 4'd0));
    send_word(compose(KIND_EXEC, OP_CALL, MODE_ABS, 64'hFFFF_FFFF_FFFF_FFF8, 4'd0,
                      MODE_NONE, 64'd0, 4'd0));
    send_word(compose(KIND_EXEC, OP_RET, MODE_NONE, 64'd0, 4'd0, MODE_NONE, 64'd0, 4'd0));
    send_word(compose(KIND_EXEC, OP_POP, MODE_REG, 64'd0, STACK_REG, MODE_NONE, 64'd0, 4'd0));
    send_word(compose(KIND_EXEC, OP_MOVRR, MODE_REG, 64'd0, 4'd2, MODE_IMM, 64'd5, 4'd0));
    send_word(compose(KIND_EXEC, OP_MOVRM, 4'd13, 64'd7, 4'd1, MODE_NONE, 64'd0, 4'd1));
    w = compose(KIND_EXEC, OP_MOVMR, MODE_IMM_BASE_SIDX, 64'd0, 4'd15, 4'd15, 64'd0, 4'd3);
    w.src_index = 4'd15;
    w.src_scale = 4'd15;
    send_word(w);
    send_word(compose(KIND_EXEC, OP_POP, MODE_IMM, 64'd9, 4'd0, MODE_NONE, 64'd0, 4'd0));
    send_word(compose(KIND_EXEC, OP_ADDRR, 4'd12, 64'd3, 4'd0, MODE_REG, 64'd0, 4'd6));
    send_word(compose(KIND_EXEC, OP_MOVRR, MODE_NONE, 64'd0, 4'd0, MODE_NONE, 64'd0, 4'd0));

    while (sent < ITEMS) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) send_word(random_word());
      else if (pick < 8) stack_run();
      else call_run();
    end
    in_tvalid <= 1'b0;

    while (board.pending() > 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
